/* rtl/log_histogram_percentile_macros.svh */
// Assertion macros used by log_histogram_percentile.sv.
`ifndef LOG_HISTOGRAM_PERCENTILE_MACROS_SVH
`define LOG_HISTOGRAM_PERCENTILE_MACROS_SVH

// Checks that the condition implies the consequent in the same cycle.
`define LHP_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("lhp assertion failed");

// Checks that the condition implies the consequent in the following cycle.
`define LHP_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("lhp assertion failed");

`endif

/* rtl/lhp_pkg.sv */
package lhp_pkg;

    localparam int MaxBuckets = 64;
    localparam int CountWidth = 32;
    localparam int IdxW       = $clog2(MaxBuckets);
    localparam int NumW       = IdxW + 1;
    localparam int NeedW      = CountWidth + 17;
    localparam int EstW       = 48;

    localparam logic [CountWidth-1:0] CntMax = '1;
    localparam logic [16:0]           OneQ16 = 17'd65536;
    localparam logic [63:0]           Sqrt2Q60 = 64'h16A09E667F3BCC91;

    localparam logic [1:0] StatOk    = 2'd0;
    localparam logic [1:0] StatEmpty = 2'd1;
    localparam logic [1:0] StatBeyond = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SQ,
        S_ADD_IDX,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_MUL,
        S_Q_RD,
        S_Q_ACC,
        S_Q_DIV,
        S_Q_EDGE,
        S_Q_MLO,
        S_Q_MHI,
        S_Q_FIN
    } t_state;

    // Power of sqrt2 in Q40.8, rounded to nearest, saturating.
    function automatic logic [EstW-1:0] edge_q8(input logic [NumW-1:0] k);
        logic [6:0]  m;
        logic [6:0]  sh;
        logic [63:0] acc;
        logic [63:0] res;
        m = {1'b0, k[NumW-1:1]};
        sh = 7'd52 - m;
        acc = '0;
        res = '0;
        if (!k[0]) begin
            if (m + 7'd8 >= 7'd48) begin
                res = {16'd0, {EstW{1'b1}}};
            end else begin
                res = 64'd1 << (m + 7'd8);
            end
        end else if (m >= 7'd40) begin
            res = {16'd0, {EstW{1'b1}}};
        end else begin
            acc = Sqrt2Q60 + (64'd1 << (sh - 7'd1));
            res = acc >> sh;
        end
        return res[EstW-1:0];
    endfunction

endpackage

/* rtl/log_histogram_percentile.sv */
// Log-spaced histogram with percentile queries. An add keeps the block busy through
// the square of the sample, the bucket search and a read-modify-write of the bucket
// memory, and its result is registered with the write. A query on an empty
// histogram or with a fraction above one answers in the cycle after the request.
// Any other query forms the target count, walks the buckets with a read step and an
// accumulate step each through the one-port bucket memory, then runs the share
// division and the interpolation (edge lookup, low multiply, high multiply, sum).
// Each result appears for exactly one cycle with o_valid and cannot be held off;
// the next request may be started in that same cycle. Reset clears the counts at
// once.
module log_histogram_percentile (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_action,
    input  logic [31:0]                    i_sample_value,
    input  logic [16:0]                    i_fraction,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [6:0]                     i_cfg_data,
    output logic                           o_valid,
    output logic [lhp_pkg::EstW-1:0]       o_estimate,
    output logic [lhp_pkg::IdxW-1:0]       o_bucket_index,
    output logic [1:0]                     o_status
);
    import lhp_pkg::*;

    `include "log_histogram_percentile_macros.svh"

    t_state r_state, n_state;

    logic [CountWidth-1:0] r_mem [MaxBuckets];
    logic [MaxBuckets-1:0] r_vld;
    logic [CountWidth-1:0] r_rd_data;
    logic                  r_rd_vld;
    logic [CountWidth-1:0] rd_cnt;
    logic                  mem_we;

    logic [6:0]            r_cfg;
    logic [NumW-1:0]       num;
    logic [CountWidth-1:0] r_total, n_total;
    logic [31:0]           r_v, n_v;
    logic [63:0]           r_sq, n_sq;
    logic [IdxW-1:0]       r_i, n_i;
    logic [IdxW-1:0]       add_idx;
    logic [16:0]           r_f, n_f;
    logic [NeedW-1:0]      r_need, n_need;
    logic [CountWidth-1:0] r_cur, n_cur;
    logic [NeedW-1:0]      r_b, n_b;
    logic [NeedW:0]        r_rem, n_rem;
    logic [16:0]           r_q, n_q;
    logic [3:0]            r_cnt, n_cnt;
    logic [EstW-1:0]       r_lo, n_lo;
    logic [EstW-1:0]       r_hi, n_hi;
    logic [40:0]           r_plo, n_plo;
    logic [40:0]           r_phi, n_phi;

    logic                  r_ovalid, n_ovalid;
    logic [EstW-1:0]       r_oest, n_oest;
    logic [IdxW-1:0]       r_oidx, n_oidx;
    logic [1:0]            r_ostat, n_ostat;

    logic                  accept;
    logic [CountWidth:0]   sum;
    logic [CountWidth-1:0] cur_new;
    logic                  hit;
    logic [NeedW-1:0]      a_val;
    logic [NeedW-1:0]      b_val;
    logic [NeedW:0]        rem2;
    logic [EstW-1:0]       diff;
    logic [65:0]           prod;
    logic [EstW:0]         est_sum;
    logic [NumW-1:0]       i_ext;

    assign num = (r_cfg == 7'd0) ? NumW'(1) :
                 (r_cfg > 7'(MaxBuckets)) ? NumW'(MaxBuckets) : NumW'(r_cfg);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign accept      = start && !busy;
    assign rd_cnt      = r_rd_vld ? r_rd_data : '0;
    assign mem_we      = (r_state == S_ADD_WR);
    assign i_ext       = {1'b0, r_i};

    assign sum     = {1'b0, r_cur} + {1'b0, rd_cnt};
    assign cur_new = (sum > {1'b0, r_total}) ? r_total : sum[CountWidth-1:0];
    assign hit     = ({1'b0, cur_new, 16'd0} >= r_need);
    assign a_val   = r_need - NeedW'({r_cur, 16'd0});
    assign b_val   = NeedW'({cur_new - r_cur, 16'd0});
    assign rem2    = {r_rem[NeedW-1:0], 1'b0};
    assign diff    = r_hi - r_lo;

    lhp_bucket_idx u_idx (
        .i_sq  (r_sq),
        .i_num (num),
        .o_idx (add_idx)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_action) begin
                        n_state = S_ADD_SQ;
                    end else if (r_total != '0 && i_fraction <= OneQ16) begin
                        n_state = S_Q_MUL;
                    end
                end
            end
            S_ADD_SQ:  n_state = S_ADD_IDX;
            S_ADD_IDX: n_state = S_ADD_RD;
            S_ADD_RD:  n_state = S_ADD_WR;
            S_ADD_WR:  n_state = S_IDLE;
            S_Q_MUL:   n_state = S_Q_RD;
            S_Q_RD:    n_state = S_Q_ACC;
            S_Q_ACC: begin
                if (hit) begin
                    n_state = S_Q_DIV;
                end else if (i_ext == num - NumW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_Q_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_Q_EDGE;
                end
            end
            S_Q_EDGE: n_state = S_Q_MLO;
            S_Q_MLO:  n_state = S_Q_MHI;
            S_Q_MHI:  n_state = S_Q_FIN;
            S_Q_FIN:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_total  = r_total;
        n_v      = r_v;
        n_sq     = r_sq;
        n_i      = r_i;
        n_f      = r_f;
        n_need   = r_need;
        n_cur    = r_cur;
        n_b      = r_b;
        n_rem    = r_rem;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_plo    = r_plo;
        n_phi    = r_phi;
        n_ovalid = 1'b0;
        n_oest   = r_oest;
        n_oidx   = r_oidx;
        n_ostat  = r_ostat;
        prod     = '0;
        est_sum  = '0;
        case (r_state)
            S_IDLE: begin
                n_v = i_sample_value;
                n_f = i_fraction;
                if (accept && i_action) begin
                    if (r_total == '0) begin
                        n_ovalid = 1'b1;
                        n_oest   = '0;
                        n_oidx   = '0;
                        n_ostat  = StatEmpty;
                    end else if (i_fraction > OneQ16) begin
                        n_ovalid = 1'b1;
                        n_oest   = edge_q8(num);
                        n_oidx   = IdxW'(num - NumW'(1));
                        n_ostat  = StatBeyond;
                    end
                end
            end
            S_ADD_SQ:  n_sq = 64'(r_v) * 64'(r_v);
            S_ADD_IDX: n_i = add_idx;
            S_ADD_WR: begin
                if (r_total != CntMax) begin
                    n_total = r_total + CountWidth'(1);
                end
                n_ovalid = 1'b1;
                n_oest   = '0;
                n_oidx   = r_i;
                n_ostat  = StatOk;
            end
            S_Q_MUL: begin
                n_need = NeedW'(r_f) * NeedW'(r_total);
                n_i    = '0;
                n_cur  = '0;
            end
            S_Q_ACC: begin
                n_cur = cur_new;
                if (hit) begin
                    n_b   = b_val;
                    n_rem = {1'b0, a_val};
                    n_q   = '0;
                    n_cnt = 4'd15;
                    if (b_val == '0) begin
                        n_cnt = '0;
                    end else if (a_val >= b_val) begin
                        n_q   = OneQ16;
                        n_cnt = '0;
                        n_b   = '0;
                    end
                end else if (i_ext == num - NumW'(1)) begin
                    n_ovalid = 1'b1;
                    n_oest   = edge_q8(num);
                    n_oidx   = IdxW'(num - NumW'(1));
                    n_ostat  = StatBeyond;
                end else begin
                    n_i = r_i + IdxW'(1);
                end
            end
            S_Q_DIV: begin
                if (r_b != '0) begin
                    if (rem2 >= {1'b0, r_b}) begin
                        n_rem = rem2 - {1'b0, r_b};
                        n_q   = {r_q[15:0], 1'b1};
                    end else begin
                        n_rem = rem2;
                        n_q   = {r_q[15:0], 1'b0};
                    end
                end
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - 4'd1;
                end
            end
            S_Q_EDGE: begin
                n_lo = (r_i == '0) ? '0 : edge_q8(i_ext);
                n_hi = edge_q8(i_ext + NumW'(1));
            end
            S_Q_MLO: n_plo = 41'(diff[23:0]) * 41'(r_q);
            S_Q_MHI: n_phi = 41'(diff[47:24]) * 41'(r_q);
            S_Q_FIN: begin
                prod    = {r_phi, 24'd0} + 66'(r_plo);
                est_sum = {1'b0, r_lo} + {1'b0, prod[63:16]};
                n_ovalid = 1'b1;
                n_oest   = est_sum[EstW] ? {EstW{1'b1}} : est_sum[EstW-1:0];
                n_oidx   = r_i;
                n_ostat  = StatOk;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= 7'(MaxBuckets);
            r_total  <= '0;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (mem_we) begin
                r_vld[r_i] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_sq    <= n_sq;
        r_i     <= n_i;
        r_f     <= n_f;
        r_need  <= n_need;
        r_cur   <= n_cur;
        r_b     <= n_b;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_plo   <= n_plo;
        r_phi   <= n_phi;
        r_oest  <= n_oest;
        r_oidx  <= n_oidx;
        r_ostat <= n_ostat;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && rd_cnt != CntMax) begin
            r_mem[r_i] <= rd_cnt + CountWidth'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_i];
        r_rd_vld  <= r_vld[r_i];
    end

    assign o_valid        = r_ovalid;
    assign o_estimate     = r_oest;
    assign o_bucket_index = r_oidx;
    assign o_status       = r_ostat;

    `LHP_ASSERT_NEXT(a_accept_busy, accept && !i_action, busy)
    `LHP_ASSERT_NOW(a_status_code, o_valid, o_status != 2'd3)
    `LHP_ASSERT_NOW(a_walk_range, r_state == S_Q_ACC, i_ext < num)
    `LHP_ASSERT_NOW(a_total_bound, r_state == S_Q_ACC, r_cur <= r_total)

endmodule

/* rtl/lhp_bucket_idx.sv */
module lhp_bucket_idx (
    input  logic [63:0]              i_sq,
    input  logic [lhp_pkg::NumW-1:0] i_num,
    output logic [lhp_pkg::IdxW-1:0] o_idx
);
    import lhp_pkg::*;

    logic [5:0] msb;
    logic [6:0] raw;

    always_comb begin
        msb = '0;
        for (int b = 1; b < 64; b++) begin
            if (i_sq[b]) begin
                msb = 6'(b);
            end
        end
        if (i_sq[63:17] != '0) begin
            raw = {1'b0, msb} - 7'd16;
        end else begin
            raw = '0;
        end
        if (raw >= 7'(i_num)) begin
            o_idx = IdxW'(i_num - NumW'(1));
        end else begin
            o_idx = raw[IdxW-1:0];
        end
    end

endmodule
